FILE: sv/fbc_pkg.sv
package fbc_pkg;

	localparam int INODE_COUNT = 64;
	localparam int BLOCK_COUNT = 256;
	localparam int BLOCK_BYTES = 512;

	localparam int CMD_W   = 2;
	localparam int SIZE_W  = 17;
	localparam int INODE_W = 6;
	localparam int VAL_W   = 8;
	localparam int STAT_W  = 2;

	localparam int IW  = $clog2(INODE_COUNT);
	localparam int IPW = $clog2(INODE_COUNT + 1);
	localparam int BW  = $clog2(BLOCK_COUNT);
	localparam int BPW = $clog2(BLOCK_COUNT + 1);
	localparam int OW  = $clog2(BLOCK_BYTES);
	localparam int CW  = SIZE_W - OW;
	localparam int AW  = BW + OW;
	localparam int BYTE_DEPTH = BLOCK_COUNT * BLOCK_BYTES;

	localparam logic [CMD_W-1:0] CMD_CREATE = 2'd0;
	localparam logic [CMD_W-1:0] CMD_WRITE  = 2'd1;
	localparam logic [CMD_W-1:0] CMD_READ   = 2'd2;

	localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
	localparam logic [STAT_W-1:0] ST_NO_INODE = 2'd1;
	localparam logic [STAT_W-1:0] ST_NO_BLOCK = 2'd2;
	localparam logic [STAT_W-1:0] ST_NO_CHAIN = 2'd3;

	typedef enum logic [3:0] {
		OP_IDLE,
		OP_LOAD,
		OP_CR_START,
		OP_CR_LINK,
		OP_NO_CHAIN,
		OP_NO_BLOCK,
		OP_HEAD_RD,
		OP_TAKE_HEAD,
		OP_LINK_RD,
		OP_TAKE_LINK,
		OP_GROW,
		OP_BYTE,
		OP_RESULT
	} op_t;

	typedef struct packed {
		op_t op;
	} ctl_t;

	typedef struct packed {
		logic is_write;
		logic no_inode;
		logic no_block;
		logic chain_ok;
		logic more;
		logic cnt_one;
		logic cur_linked;
	} sts_t;

endpackage

FILE: sv/fbc_datapath.sv
module fbc_datapath (
	input  logic                           clk,
	input  logic                           arst_n,
	input  fbc_pkg::ctl_t                  ctl,
	output fbc_pkg::sts_t                  sts,
	input  logic [fbc_pkg::CMD_W-1:0]      command,
	input  logic [fbc_pkg::SIZE_W-1:0]     file_bytes,
	input  logic [fbc_pkg::INODE_W-1:0]    inode_index,
	input  logic [fbc_pkg::SIZE_W-1:0]     byte_position,
	input  logic [fbc_pkg::VAL_W-1:0]      write_value,
	output logic [fbc_pkg::STAT_W-1:0]     status,
	output logic [fbc_pkg::INODE_W-1:0]    claimed_inode,
	output logic [fbc_pkg::VAL_W-1:0]      read_value
);
	import fbc_pkg::*;

	logic [IPW-1:0]         inode_ptr_q;
	logic [BPW-1:0]         blk_ptr_q;
	logic [INODE_COUNT-1:0] chained_q;
	logic [BLOCK_COUNT-1:0] linked_q;

	logic [BW-1:0]    head_mem [INODE_COUNT];
	logic [BW-1:0]    link_mem [BLOCK_COUNT];
	logic [VAL_W-1:0] byte_mem [BYTE_DEPTH];

	logic [CMD_W-1:0]   cmd_q;
	logic [INODE_W-1:0] node_q;
	logic [CW-1:0]      cnt_q;
	logic [OW-1:0]      off_q;
	logic [VAL_W-1:0]   val_q;
	logic [BW-1:0]      cur_q;
	logic [BW-1:0]      head_rd_q;
	logic [BW-1:0]      link_rd_q;
	logic [VAL_W-1:0]   byte_rd_q;
	logic [STAT_W-1:0]  st_q;
	logic [INODE_W-1:0] made_q;

	logic          no_inode;
	logic          no_block;
	logic          in_range;
	logic [IW-1:0] node_idx;
	logic [BW-1:0] free_blk;
	logic [AW-1:0] byte_addr;

	assign no_inode  = inode_ptr_q == IPW'(INODE_COUNT);
	assign no_block  = blk_ptr_q == BPW'(BLOCK_COUNT);
	assign in_range  = 32'(node_q) < INODE_COUNT;
	assign node_idx  = IW'(node_q);
	assign free_blk  = blk_ptr_q[BW-1:0];
	assign byte_addr = {cur_q, off_q};

	assign sts.is_write   = cmd_q == CMD_WRITE;
	assign sts.no_inode   = no_inode;
	assign sts.no_block   = no_block;
	assign sts.chain_ok   = in_range && chained_q[node_idx];
	assign sts.more       = cnt_q != '0;
	assign sts.cnt_one    = cnt_q == CW'(1);
	assign sts.cur_linked = linked_q[cur_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inode_ptr_q <= '0;
			blk_ptr_q   <= '0;
			chained_q   <= '0;
			linked_q    <= '0;
		end else begin
			unique case (ctl.op)
				OP_CR_START: begin
					if (!no_inode)
						inode_ptr_q <= inode_ptr_q + IPW'(1);
					if (!no_block)
						blk_ptr_q <= blk_ptr_q + BPW'(1);
					if (!no_inode && !no_block)
						chained_q[inode_ptr_q[IW-1:0]] <= 1'b1;
				end
				OP_CR_LINK, OP_GROW: begin
					if (!no_block) begin
						linked_q[cur_q] <= 1'b1;
						blk_ptr_q       <= blk_ptr_q + BPW'(1);
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (ctl.op)
			OP_LOAD: begin
				cmd_q  <= command;
				node_q <= inode_index;
				cnt_q  <= (command == CMD_CREATE) ? file_bytes[SIZE_W-1:OW]
				                                  : byte_position[SIZE_W-1:OW];
				off_q  <= byte_position[OW-1:0];
				val_q  <= write_value;
				st_q   <= ST_OK;
				made_q <= '0;
			end
			OP_CR_START: begin
				if (no_inode)
					st_q <= ST_NO_INODE;
				else if (no_block)
					st_q <= ST_NO_BLOCK;
				else begin
					head_mem[inode_ptr_q[IW-1:0]] <= free_blk;
					cur_q  <= free_blk;
					made_q <= INODE_W'(inode_ptr_q);
				end
			end
			OP_CR_LINK, OP_GROW: begin
				if (no_block) begin
					st_q   <= ST_NO_BLOCK;
					made_q <= '0;
				end else begin
					link_mem[cur_q] <= free_blk;
					cur_q <= free_blk;
					cnt_q <= cnt_q - CW'(1);
				end
			end
			OP_NO_CHAIN:  st_q <= ST_NO_CHAIN;
			OP_NO_BLOCK:  st_q <= ST_NO_BLOCK;
			OP_HEAD_RD:   head_rd_q <= head_mem[node_idx];
			OP_TAKE_HEAD: cur_q <= head_rd_q;
			OP_LINK_RD: begin
				link_rd_q <= link_mem[cur_q];
				cnt_q     <= cnt_q - CW'(1);
			end
			OP_TAKE_LINK: cur_q <= link_rd_q;
			OP_BYTE: begin
				if (cmd_q == CMD_WRITE)
					byte_mem[byte_addr] <= val_q;
				byte_rd_q <= byte_mem[byte_addr];
			end
			OP_RESULT: begin
				status        <= st_q;
				claimed_inode <= made_q;
				read_value    <= (cmd_q == CMD_READ && st_q == ST_OK) ? byte_rd_q : '0;
			end
			default: ;
		endcase
	end

endmodule

FILE: sv/fbc_ctrl.sv
module fbc_ctrl (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic [fbc_pkg::CMD_W-1:0] command,
	output logic                      out_valid,
	input  logic                      out_stall,
	input  fbc_pkg::sts_t             sts,
	output fbc_pkg::ctl_t             ctl
);
	import fbc_pkg::*;

	typedef enum logic [8:0] {
		S_IDLE     = 9'b000000001,
		S_CR_START = 9'b000000010,
		S_CR_CHAIN = 9'b000000100,
		S_WK_START = 9'b000001000,
		S_WK_HEAD  = 9'b000010000,
		S_WK_STEP  = 9'b000100000,
		S_WK_LINK  = 9'b001000000,
		S_BYTE     = 9'b010000000,
		S_RESP     = 9'b100000000
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   out_free;

	assign in_stall  = state_q != S_IDLE;
	assign out_valid = out_valid_q;
	assign out_free  = !out_valid_q || !out_stall;

	always_comb begin
		state_d = state_q;
		ctl.op  = OP_IDLE;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					ctl.op = OP_LOAD;
					if (command == CMD_CREATE)
						state_d = S_CR_START;
					else if (command == CMD_WRITE || command == CMD_READ)
						state_d = S_WK_START;
					else
						state_d = S_RESP;
				end
			end
			S_CR_START: begin
				ctl.op = OP_CR_START;
				if (sts.no_inode || sts.no_block || !sts.more)
					state_d = S_RESP;
				else
					state_d = S_CR_CHAIN;
			end
			S_CR_CHAIN: begin
				ctl.op = OP_CR_LINK;
				if (sts.no_block || sts.cnt_one)
					state_d = S_RESP;
			end
			S_WK_START: begin
				if (sts.chain_ok) begin
					ctl.op  = OP_HEAD_RD;
					state_d = S_WK_HEAD;
				end else begin
					ctl.op  = OP_NO_CHAIN;
					state_d = S_RESP;
				end
			end
			S_WK_HEAD: begin
				ctl.op  = OP_TAKE_HEAD;
				state_d = S_WK_STEP;
			end
			S_WK_STEP: begin
				priority if (!sts.more)
					state_d = S_BYTE;
				else if (sts.cur_linked) begin
					ctl.op  = OP_LINK_RD;
					state_d = S_WK_LINK;
				end else if (!sts.is_write) begin
					ctl.op  = OP_NO_CHAIN;
					state_d = S_RESP;
				end else if (sts.no_block) begin
					ctl.op  = OP_NO_BLOCK;
					state_d = S_RESP;
				end else
					ctl.op = OP_GROW;
			end
			S_WK_LINK: begin
				ctl.op  = OP_TAKE_LINK;
				state_d = S_WK_STEP;
			end
			S_BYTE: begin
				ctl.op  = OP_BYTE;
				state_d = S_RESP;
			end
			S_RESP: begin
				if (out_free) begin
					ctl.op  = OP_RESULT;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_RESP && out_free)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

endmodule

FILE: sv/file_block_chain_engine.sv
// file block chain engine: inodes own linked chains of data blocks
// input channel: in_valid / in_stall with command, file_bytes, inode_index,
// byte_position and write_value; one command is in flight at a time
// output channel: out_valid / out_stall with status, claimed_inode, read_value,
// exactly one result per command, held steady while out_stall is high
// create claims the head block, then links one more block per chain step
// write and read walk the chain through the one-read-port link table, each
// hop a registered read then a take; a write appends any missing block
// byte access: a single-port byte memory, read data registered
// a new command is taken once the previous result sits in the output
// register; the engine then waits there only while that result is stalled
// blocks and inodes are handed out lowest first and never freed, so the
// free pool is a pointer and no scan is needed
// reset (arst_n low) frees every inode and block at once; the byte and link
// memories keep their contents, and a link is only read after being written
module file_block_chain_engine (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [fbc_pkg::CMD_W-1:0]     command,
	input  logic [fbc_pkg::SIZE_W-1:0]    file_bytes,
	input  logic [fbc_pkg::INODE_W-1:0]   inode_index,
	input  logic [fbc_pkg::SIZE_W-1:0]    byte_position,
	input  logic [fbc_pkg::VAL_W-1:0]     write_value,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [fbc_pkg::STAT_W-1:0]    status,
	output logic [fbc_pkg::INODE_W-1:0]   claimed_inode,
	output logic [fbc_pkg::VAL_W-1:0]     read_value
);
	import fbc_pkg::*;

	ctl_t ctl;
	sts_t sts;

	fbc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.command   (command),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.ctl       (ctl)
	);

	fbc_datapath u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.ctl           (ctl),
		.sts           (sts),
		.command       (command),
		.file_bytes    (file_bytes),
		.inode_index   (inode_index),
		.byte_position (byte_position),
		.write_value   (write_value),
		.status        (status),
		.claimed_inode (claimed_inode),
		.read_value    (read_value)
	);

	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("second command taken while one is in flight");

	a_fail_no_inode: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status != ST_OK) |-> claimed_inode == '0)
		else $error("failed command reports an inode");

	a_fail_no_data: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status != ST_OK) |-> read_value == '0)
		else $error("failed command reports read data");

endmodule

FILE: tb/fbc_checker.sv
`timescale 1ns / 100ps

module fbc_checker
	import fbc_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                in_stall,
	input  logic [CMD_W-1:0]    command,
	input  logic [SIZE_W-1:0]   file_bytes,
	input  logic [INODE_W-1:0]  inode_index,
	input  logic [SIZE_W-1:0]   byte_position,
	input  logic [VAL_W-1:0]    write_value,
	input  logic                out_valid,
	input  logic                out_stall,
	input  logic [STAT_W-1:0]   status,
	input  logic [INODE_W-1:0]  claimed_inode,
	input  logic [VAL_W-1:0]    read_value,
	output int                  fails,
	output int                  pending
);

	localparam logic [1:0] SLOT_FREE   = 2'd0;
	localparam logic [1:0] BLK_LAST    = 2'd1;
	localparam logic [1:0] BLK_LINKED  = 2'd2;
	localparam logic [1:0] INO_CLAIMED = 2'd1;
	localparam logic [1:0] INO_CHAINED = 2'd2;

	typedef struct packed {
		logic [STAT_W-1:0]  st;
		logic [INODE_W-1:0] ino;
		logic [VAL_W-1:0]   rv;
	} fs_answer_t;

	logic [1:0]       ino_mark[INODE_COUNT];
	logic [BW-1:0]    ino_head[INODE_COUNT];
	int               ino_blocks[INODE_COUNT];
	logic [1:0]       blk_mark[BLOCK_COUNT];
	logic [BW-1:0]    blk_next[BLOCK_COUNT];
	logic [VAL_W-1:0] disk[BYTE_DEPTH];
	fs_answer_t       answers_q[$];

	function automatic int take_inode();
		for (int i = 0; i < INODE_COUNT; i++)
			if (ino_mark[i] == SLOT_FREE) begin
				ino_mark[i] = INO_CLAIMED;
				return i;
			end
		return -1;
	endfunction

	function automatic int take_block();
		for (int i = 0; i < BLOCK_COUNT; i++)
			if (blk_mark[i] == SLOT_FREE) begin
				blk_mark[i] = BLK_LAST;
				return i;
			end
		return -1;
	endfunction

	function automatic fs_answer_t run_command(logic [CMD_W-1:0] cmd, int fbytes, int ino,
			int pos, logic [VAL_W-1:0] val);
		fs_answer_t a;
		int need, n, cur, nb, want, addr;
		bit ok;
		a = '0;
		if (cmd == CMD_CREATE) begin
			need = fbytes / BLOCK_BYTES + 1;
			n = take_inode();
			cur = take_block();
			if (n < 0)
				a.st = ST_NO_INODE;
			else if (cur < 0)
				a.st = ST_NO_BLOCK;
			else begin
				ino_mark[n] = INO_CHAINED;
				ino_head[n] = BW'(cur);
				ino_blocks[n] = 1;
				ok = 1;
				for (int k = 1; k < need; k++) begin
					nb = take_block();
					if (nb < 0) begin
						ok = 0;
						break;
					end
					blk_next[cur] = BW'(nb);
					blk_mark[cur] = BLK_LINKED;
					ino_blocks[n]++;
					cur = nb;
				end
				if (ok)
					a.ino = INODE_W'(n);
				else
					a.st = ST_NO_BLOCK;
			end
		end else if (cmd == CMD_WRITE || cmd == CMD_READ) begin
			if (ino >= INODE_COUNT || ino_mark[ino] != INO_CHAINED)
				a.st = ST_NO_CHAIN;
			else begin
				cur = int'(ino_head[ino]);
				want = pos / BLOCK_BYTES;
				for (int k = 0; k < want; k++) begin
					if (blk_mark[cur] == BLK_LINKED)
						cur = int'(blk_next[cur]);
					else if (cmd == CMD_READ) begin
						a.st = ST_NO_CHAIN;
						break;
					end else begin
						nb = take_block();
						if (nb < 0) begin
							a.st = ST_NO_BLOCK;
							break;
						end
						blk_next[cur] = BW'(nb);
						blk_mark[cur] = BLK_LINKED;
						ino_blocks[ino]++;
						cur = nb;
					end
				end
				if (a.st == ST_OK) begin
					addr = cur * BLOCK_BYTES + pos % BLOCK_BYTES;
					if (cmd == CMD_WRITE)
						disk[addr] = val;
					else
						a.rv = disk[addr];
				end
			end
		end
		return a;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		fs_answer_t exp_a;
		if (!arst_n) begin
			for (int i = 0; i < INODE_COUNT; i++) begin
				ino_mark[i] = SLOT_FREE;
				ino_head[i] = '0;
				ino_blocks[i] = 0;
			end
			for (int i = 0; i < BLOCK_COUNT; i++)
				blk_mark[i] = SLOT_FREE;
			answers_q.delete();
			fails = 0;
			pending = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (answers_q.size() == 0) begin
					fails++;
					if (fails <= 10)
						$display("unexpected result transfer: status %0d inode %0d value %0d",
							status, claimed_inode, read_value);
				end else begin
					exp_a = answers_q.pop_front();
					if (status !== exp_a.st || claimed_inode !== exp_a.ino ||
							read_value !== exp_a.rv) begin
						fails++;
						if (fails <= 10)
							$display("mismatch: expected %0d %0d %0d, got %0d %0d %0d",
								exp_a.st, exp_a.ino, exp_a.rv, status, claimed_inode,
								read_value);
					end
				end
			end
			if (in_valid && !in_stall)
				answers_q.push_back(run_command(command, int'(file_bytes),
					int'(inode_index), int'(byte_position), write_value));
			pending = answers_q.size();
		end
	end

endmodule

FILE: tb/tb.sv
`timescale 1ns / 100ps

module tb;
	import fbc_pkg::*;

	localparam int CYCLE_LIMIT = 600000;

	logic                clk = 0;
	logic                arst_n = 0;
	logic                in_valid = 0;
	logic                in_stall;
	logic [CMD_W-1:0]    command = CMD_CREATE;
	logic [SIZE_W-1:0]   file_bytes = '0;
	logic [INODE_W-1:0]  inode_index = '0;
	logic [SIZE_W-1:0]   byte_position = '0;
	logic [VAL_W-1:0]    write_value = '0;
	logic                out_valid;
	logic                out_stall = 0;
	logic [STAT_W-1:0]   status;
	logic [INODE_W-1:0]  claimed_inode;
	logic [VAL_W-1:0]    read_value;
	int                  fails, pending;
	int                  idle_pct = 0, stall_pct = 0;
	int                  cycles = 0;
	int                  creates_sent = 0;
	int                  wr_ino[$], wr_pos[$];

	always #4 clk = ~clk;

	file_block_chain_engine DUT (.*);

	fbc_checker u_checker (.*);

	always @(posedge clk)
		out_stall <= ($urandom_range(0, 99) < stall_pct);

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	task automatic send(logic [CMD_W-1:0] cmd, int fb, int ino, int pos, int val);
		while ($urandom_range(0, 99) < idle_pct) begin
			in_valid <= 0;
			@(posedge clk);
		end
		in_valid <= 1;
		command <= cmd;
		file_bytes <= SIZE_W'(fb);
		inode_index <= INODE_W'(ino);
		byte_position <= SIZE_W'(pos);
		write_value <= VAL_W'(val);
		if (cmd == CMD_CREATE)
			creates_sent++;
		if (cmd == CMD_WRITE && ino < creates_sent) begin
			wr_ino.push_back(ino);
			wr_pos.push_back(pos);
		end
		do
			@(posedge clk);
		while (in_stall);
	endtask

	task automatic send_random();
		int roll, j;
		roll = $urandom_range(0, 99);
		if (roll < 25 && creates_sent < 40)
			send(CMD_CREATE, ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2047) :
				$urandom_range(0, 511), $urandom_range(0, 63), $urandom_range(0, 131071),
				$urandom_range(0, 255));
		else if (roll < 65)
			send(CMD_WRITE, $urandom_range(0, 131071),
				($urandom_range(0, 9) == 0) ? $urandom_range(0, 63) :
				$urandom_range(0, creates_sent - 1), $urandom_range(0, 1535),
				$urandom_range(0, 255));
		else if (wr_ino.size() > 0 && ($urandom_range(0, 99) < 85 || creates_sent >= 64)) begin
			j = $urandom_range(0, wr_ino.size() - 1);
			send(CMD_READ, $urandom_range(0, 131071), wr_ino[j], wr_pos[j],
				$urandom_range(0, 255));
		end else
			send(CMD_READ, $urandom_range(0, 131071), $urandom_range(creates_sent, 63),
				$urandom_range(0, 131071), $urandom_range(0, 255));
	endtask

	task automatic drain();
		in_valid <= 0;
		@(posedge clk);
		wait (pending == 0);
		@(posedge clk);
	endtask

	initial begin
		int top_ino;
		repeat (7) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: small files, edges of the byte range, chain end, unchained inode
		send(CMD_CREATE, 0, 0, 0, 0);
		send(CMD_CREATE, 1023, 0, 0, 0);
		send(CMD_WRITE, 0, 0, 0, 8'hFF);
		send(CMD_WRITE, 0, 0, 511, 8'h00);
		send(CMD_WRITE, 0, 1, 1023, 8'hA5);
		send(CMD_READ, 0, 0, 0, 0);
		send(CMD_READ, 0, 0, 511, 0);
		send(CMD_READ, 0, 1, 1023, 0);
		send(CMD_READ, 0, 1, 1024, 0);
		send(CMD_WRITE, 0, 63, 0, 8'h5A);
		send(CMD_READ, 0, 63, 0, 0);
		send(CMD_WRITE, 0, 0, 600, 8'h81);
		send(CMD_READ, 0, 0, 600, 0);
		drain();

		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin idle_pct = 0;  stall_pct = 0;  end
				1: begin idle_pct = 73; stall_pct = 0;  end
				2: begin idle_pct = 0;  stall_pct = 73; end
				default: begin idle_pct = 27; stall_pct = 27; end
			endcase
			for (int n = 0; n < 150; n++)
				send_random();
			drain();
		end

		// exhaustion: chain runs out in create, then no block, then no inode
		send(CMD_CREATE, 131071, 0, 0, 0);
		top_ino = creates_sent - 1;
		send(CMD_WRITE, 0, top_ino, 5, 8'h3C);
		send(CMD_READ, 0, top_ino, 5, 0);
		send(CMD_WRITE, 0, 0, 131071, 8'hC3);
		send(CMD_READ, 0, 0, 131071, 0);
		send(CMD_CREATE, 0, 0, 0, 0);
		while (creates_sent < 66)
			send(CMD_CREATE, 131071, 0, 0, 0);
		drain();
		repeat (50) @(posedge clk);

		if (fails == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
